/* rtl/slqe_pkg.sv */
// ----------------------------------------------------------------------------
// slqe_pkg
// Shared types and constants for the sorted list queue engine.
// ----------------------------------------------------------------------------
package slqe_pkg;

    localparam int CAPACITY_DEFAULT = 256;
    localparam int VALUE_W          = 31;
    localparam int COUNT_OUT_W      = 9;

    typedef enum logic [2:0] {
        OP_PUSH   = 3'd0,
        OP_POP    = 3'd1,
        OP_INSERT = 3'd2,
        OP_ERASE  = 3'd3,
        OP_GET    = 3'd4,
        OP_CLEAR  = 3'd5
    } op_t;

endpackage

/* rtl/sorted_list_queue_engine.sv */
// ----------------------------------------------------------------------------
// sorted_list_queue_engine
// Bounded ordered list held in a circular single-port memory.
// ----------------------------------------------------------------------------
// Each request gives one response. Insert scans the list from the head for
// its place, reading one entry at a time, and then shifts the tail up by one
// entry. Erase reads every entry once and writes back the survivors. The time
// that insert and erase take grows with the length of the list, since every
// read and write passes through the one memory port. The store needs no
// clearing after reset.
module sorted_list_queue_engine #(
    parameter int CAPACITY = slqe_pkg::CAPACITY_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // tdata: [2:0] operation, [34:3] entry_value, [50:35] position, [55:51] zero
    input  logic [55:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // tdata: [31:0] read_value, [32] success, [41:33] element_count, [47:42] zero
    output logic [47:0] m_tdata
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int VW = slqe_pkg::VALUE_W;
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    typedef enum logic [3:0] {
        S_IDLE, S_DECODE, S_READ_WAIT, S_FIND_RD, S_FIND, S_SHIFT_RD, S_SHIFT_WR,
        S_ERASE_RD, S_ERASE_CHK, S_DONE
    } state_t;

    state_t         state_reg;
    logic [AW-1:0]  front_reg;
    logic [CW-1:0]  count_reg;
    logic [2:0]     op_reg;
    logic [VW-1:0]  val_reg;
    logic           neg_reg;
    logic [15:0]    pos_reg;
    logic [CW-1:0]  idx_reg;   // scan / shift index
    logic [CW-1:0]  wr_reg;    // compaction write index
    logic [31:0]    rd_reg;
    logic           ok_reg;
    logic           out_valid_reg;
    logic [47:0]    out_data_reg;

    // Single-port memory with registered read.
    logic [VW-1:0]  mem [CAPACITY];
    logic           mem_we;
    logic [AW-1:0]  mem_addr;
    logic [VW-1:0]  mem_wdata;
    logic [VW-1:0]  mem_q;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= mem_wdata;
        end
        mem_q <= mem[mem_addr];
    end

    // Logical index to physical slot, modulo CAPACITY.
    function automatic logic [AW-1:0] slot(input logic [AW-1:0] f, input logic [CW-1:0] i);
        logic [CW:0] s;
        begin
            s = {1'b0, i} + (CW+1)'(f);
            if (s >= (CW+1)'(CAPACITY))
            begin
                s = s - (CW+1)'(CAPACITY);
            end
            slot = s[AW-1:0];
        end
    endfunction

    assign s_tready = (state_reg == S_IDLE) && !(out_valid_reg && !m_tready);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // Memory port control.
    always_comb
    begin
        mem_we    = 1'b0;
        mem_addr  = '0;
        mem_wdata = val_reg;
        unique case (state_reg)
            S_DECODE:
            begin
                if (op_reg == slqe_pkg::OP_PUSH && !neg_reg && count_reg < CAP_C)
                begin
                    mem_we   = 1'b1;
                    mem_addr = slot(front_reg, count_reg);
                end
                else if (op_reg == slqe_pkg::OP_POP)
                begin
                    mem_addr = front_reg;
                end
                else if (op_reg == slqe_pkg::OP_GET)
                begin
                    mem_addr = slot(front_reg, CW'(pos_reg));
                end
                else
                begin
                    mem_addr = slot(front_reg, idx_reg);
                end
            end
            S_FIND_RD, S_FIND, S_ERASE_CHK, S_READ_WAIT:
                mem_addr = slot(front_reg, idx_reg);
            S_SHIFT_RD:  mem_addr = slot(front_reg, idx_reg - CW'(1));
            S_SHIFT_WR:
            begin
                mem_we    = 1'b1;
                mem_addr  = slot(front_reg, idx_reg);
                mem_wdata = mem_q;
            end
            S_ERASE_RD:  mem_addr = slot(front_reg, idx_reg);
            default:     mem_addr = '0;
        endcase
        // Final write of the inserted value.
        if (state_reg == S_SHIFT_RD && idx_reg == wr_reg)
        begin
            mem_we    = 1'b1;
            mem_addr  = slot(front_reg, idx_reg);
            mem_wdata = val_reg;
        end
        // Compaction writes a survivor.
        if (state_reg == S_ERASE_CHK && mem_q != val_reg)
        begin
            mem_we    = 1'b1;
            mem_addr  = slot(front_reg, wr_reg);
            mem_wdata = mem_q;
        end
    end

    // Sequencer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            front_reg     <= '0;
            count_reg     <= '0;
            op_reg        <= '0;
            val_reg       <= '0;
            neg_reg       <= 1'b0;
            pos_reg       <= '0;
            idx_reg       <= '0;
            wr_reg        <= '0;
            rd_reg        <= '0;
            ok_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            // The response register fills in the done state and empties on acceptance.
            if (state_reg == S_DONE)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (s_tvalid && s_tready)
                    begin
                        op_reg    <= s_tdata[2:0];
                        neg_reg   <= s_tdata[34];
                        val_reg   <= s_tdata[33:3];
                        pos_reg   <= s_tdata[50:35];
                        idx_reg   <= '0;
                        wr_reg    <= '0;
                        rd_reg    <= '0;
                        ok_reg    <= 1'b0;
                        state_reg <= S_DECODE;
                    end
                end
                S_DECODE:
                begin
                    state_reg <= S_DONE;
                    priority case (op_reg)
                        slqe_pkg::OP_PUSH:
                        begin
                            if (!neg_reg && count_reg < CAP_C)
                            begin
                                count_reg <= count_reg + CW'(1);
                                ok_reg    <= 1'b1;
                            end
                        end
                        slqe_pkg::OP_POP:
                        begin
                            if (count_reg == '0)
                            begin
                                rd_reg <= '1;
                            end
                            else
                            begin
                                state_reg <= S_READ_WAIT;
                            end
                        end
                        slqe_pkg::OP_GET:
                        begin
                            if ({16'd0, pos_reg} < 32'(count_reg))
                            begin
                                state_reg <= S_READ_WAIT;
                            end
                            else
                            begin
                                rd_reg <= '1;
                            end
                        end
                        slqe_pkg::OP_INSERT:
                        begin
                            if (!neg_reg && count_reg < CAP_C)
                            begin
                                ok_reg <= 1'b1;
                                if (count_reg == '0)
                                begin
                                    wr_reg    <= '0;
                                    idx_reg   <= '0;
                                    state_reg <= S_SHIFT_RD;
                                end
                                else
                                begin
                                    state_reg <= S_FIND;
                                end
                            end
                        end
                        slqe_pkg::OP_ERASE:
                        begin
                            if (!neg_reg && count_reg != '0)
                            begin
                                state_reg <= S_ERASE_RD;
                            end
                        end
                        slqe_pkg::OP_CLEAR:
                        begin
                            count_reg <= '0;
                            front_reg <= '0;
                            ok_reg    <= 1'b1;
                        end
                        default: ;
                    endcase
                end
                S_READ_WAIT:
                begin
                    rd_reg    <= {1'b0, mem_q};
                    ok_reg    <= 1'b1;
                    state_reg <= S_DONE;
                    if (op_reg == slqe_pkg::OP_POP)
                    begin
                        front_reg <= slot(front_reg, CW'(1));
                        count_reg <= count_reg - CW'(1);
                    end
                end
                S_FIND_RD:
                begin
                    // Read of entry idx_reg is issued here for the next compare.
                    state_reg <= S_FIND;
                end
                S_FIND:
                begin
                    // mem_q holds entry idx_reg (read issued last cycle).
                    if ((idx_reg == '0) ? (val_reg > mem_q) : (mem_q <= val_reg))
                    begin
                        wr_reg    <= idx_reg;
                        idx_reg   <= count_reg;
                        state_reg <= S_SHIFT_RD;
                    end
                    else if (idx_reg + CW'(1) == count_reg)
                    begin
                        wr_reg    <= count_reg;
                        idx_reg   <= count_reg;
                        state_reg <= S_SHIFT_RD;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + CW'(1);
                        state_reg <= S_FIND_RD;
                    end
                end
                S_SHIFT_RD:
                begin
                    if (idx_reg == wr_reg)
                    begin
                        count_reg <= count_reg + CW'(1);
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        state_reg <= S_SHIFT_WR;
                    end
                end
                S_SHIFT_WR:
                begin
                    idx_reg   <= idx_reg - CW'(1);
                    state_reg <= S_SHIFT_RD;
                end
                S_ERASE_RD:
                begin
                    state_reg <= S_ERASE_CHK;
                end
                S_ERASE_CHK:
                begin
                    if (mem_q == val_reg)
                    begin
                        ok_reg <= 1'b1;
                    end
                    else
                    begin
                        wr_reg <= wr_reg + CW'(1);
                    end
                    if (idx_reg + CW'(1) == count_reg)
                    begin
                        count_reg <= (mem_q == val_reg) ? wr_reg : wr_reg + CW'(1);
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + CW'(1);
                        state_reg <= S_ERASE_RD;
                    end
                end
                S_DONE:
                begin
                    if (!out_valid_reg || m_tready)
                    begin
                        out_data_reg  <= {6'd0, 9'(count_reg), ok_reg, rd_reg};
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule
